// File: rtl/assert_macros.svh
// Assertion macros shared by the read sequencer RTL.
// Each macro expects clk and rst_n to be in scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NLPRS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NLPRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/nlprs_pkg.sv
// Package for the NAND large-page read sequencer: widths, codes and the job type.
// Used by the interfaces and by every module of the block.
`timescale 1ns / 1ps

package nlprs_pkg;

  localparam int PAGE_BYTES = 2048;
  localparam int PAGE_W     = $clog2(PAGE_BYTES);
  localparam int ADDR_W     = 29;
  localparam int COUNT_W    = 30;
  localparam int BYTE_W     = 8;
  localparam int OP_W       = 2;
  localparam int ACT_W      = 3;
  localparam int STEP_W     = 3;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Input operation codes.
  localparam logic [OP_W-1:0] OP_START  = 2'd0;
  localparam logic [OP_W-1:0] OP_STATUS = 2'd1;
  localparam logic [OP_W-1:0] OP_DATA   = 2'd2;
  localparam logic [OP_W-1:0] OP_RESET  = 2'd3;

  // Result action codes.
  localparam logic [ACT_W-1:0] ACT_SELECT   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_CMD      = 3'd1;
  localparam logic [ACT_W-1:0] ACT_ADDR     = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DATA     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DESELECT = 3'd4;
  localparam logic [ACT_W-1:0] ACT_REFUSED  = 3'd5;

  // Flash command bytes.
  localparam logic [BYTE_W-1:0] CMD_READ0  = 8'h00;
  localparam logic [BYTE_W-1:0] CMD_READ1  = 8'h30;
  localparam logic [BYTE_W-1:0] CMD_RESET  = 8'hff;

  // Jobs handed from the front end to the back end; each expands to a
  // fixed sequence of result items.
  typedef enum logic [2:0] {
    JOB_REFUSED,     // refused
    JOB_SEL_DESEL,   // select, deselect
    JOB_SEL_PAGE,    // select, seven page command items
    JOB_DATA,        // data
    JOB_DATA_DESEL,  // data, deselect
    JOB_DATA_PAGE,   // data, seven page command items
    JOB_DESEL,       // deselect
    JOB_RESET        // select, reset command
  } job_kind_t;

  typedef struct packed {
    job_kind_t         kind;
    logic [BYTE_W-1:0] data_byte;
    logic [ADDR_W-1:0] offset;
    logic [ADDR_W-1:0] addr;
  } job_t;

endpackage

// File: rtl/nlprs_if.sv
// Valid/ready channel interfaces for the read sequencer input and result items.
// Depends on nlprs_pkg for the field widths.
`timescale 1ns / 1ps

interface nlprs_in_if;
  logic                             valid;
  logic                             ready;
  logic [nlprs_pkg::OP_W-1:0]       operation;
  logic [nlprs_pkg::ADDR_W-1:0]     start_address;
  logic [nlprs_pkg::COUNT_W-1:0]    byte_count;
  logic                             ready_req;
  logic [nlprs_pkg::BYTE_W-1:0]     flash_byte;

  modport source (output valid, operation, start_address, byte_count, ready_req,
                  flash_byte, input ready);
  modport sink   (input valid, operation, start_address, byte_count, ready_req,
                  flash_byte, output ready);
endinterface

interface nlprs_out_if;
  logic                             valid;
  logic                             ready;
  logic [nlprs_pkg::ACT_W-1:0]      action;
  logic [nlprs_pkg::BYTE_W-1:0]     bus_byte;
  logic [nlprs_pkg::ADDR_W-1:0]     buffer_offset;
  logic                             last;

  modport source (output valid, action, bus_byte, buffer_offset, last, input ready);
  modport sink   (input valid, action, bus_byte, buffer_offset, last, output ready);
endinterface

// File: rtl/nand_large_page_read_sequencer.sv
// Top level of the NAND large-page read sequencer.
// Depends on nlprs_pkg, nlprs_if, nlprs_front, nlprs_fifo and nlprs_back.
//
//   Channel  Port    Direction  Contents
//   input    in_ch   sink       operation, start_address, byte_count, ready_req, flash_byte
//   result   out_ch  source     action, bus_byte, buffer_offset, last
//
// The front end takes one input item per cycle while the four-entry job queue has room.
// Each job leaves the back end as one to eight result items, one per cycle from the
// output register while out_ch.ready is high: eight for a page end, one for a data byte.
// Reset (rst_n low, synchronous) returns the sequencer to idle with an empty queue.
// A stalled result port fills the queue, after which in_ch.ready drops.
`timescale 1ns / 1ps

module nand_large_page_read_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  nlprs_in_if.sink    in_ch,
  nlprs_out_if.source out_ch
);
  import nlprs_pkg::*;

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  job_t push_job;
  job_t head;

  nlprs_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .job    (push_job)
  );

  nlprs_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  nlprs_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (q_empty),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// File: rtl/nlprs_front.sv
// Front end: accepts input items, runs the read state machine and emits jobs.
// Depends on nlprs_pkg, nlprs_in_if and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nlprs_front (
  input  logic             clk,
  input  logic             rst_n,
  nlprs_in_if.sink         in_ch,
  input  logic             q_full,
  output logic             push,
  output nlprs_pkg::job_t  job
);
  import nlprs_pkg::*;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_WAIT  = 2'd1;
  localparam logic [1:0] PH_DATA  = 2'd2;
  localparam logic [1:0] PH_RESET = 2'd3;

  logic [1:0]        phase_r, phase_nxt;
  logic [ADDR_W-1:0] cur_addr_r, cur_addr_nxt;
  logic [ADDR_W-1:0] end_addr_r, end_addr_nxt;
  logic [PAGE_W-1:0] bip_r, bip_nxt;
  logic [ADDR_W-1:0] buf_pos_r, buf_pos_nxt;

  logic              accept;
  logic              refuse;
  logic [ADDR_W-1:0] cur_inc;
  logic              refused_start;
  logic              reset_taken;

  // An item is taken whenever the job queue has room.
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cur_inc     = cur_addr_r + {{(ADDR_W-1){1'b0}}, 1'b1};

  // A start is refused when busy, misaligned or larger than the address space.
  assign refuse = (phase_r != PH_IDLE)
               || (in_ch.start_address[PAGE_W-1:0] != '0)
               || (in_ch.byte_count[PAGE_W-1:0] != '0)
               || (in_ch.byte_count[COUNT_W-1] && (in_ch.byte_count[COUNT_W-2:0] != '0));

  // Accepted items that the checks below look at.
  assign refused_start = accept && (in_ch.operation == OP_START) && refuse;
  assign reset_taken   = accept && (in_ch.operation == OP_RESET);

  // Next state and the job for the accepted item.
  always_comb begin
    phase_nxt    = phase_r;
    cur_addr_nxt = cur_addr_r;
    end_addr_nxt = end_addr_r;
    bip_nxt      = bip_r;
    buf_pos_nxt  = buf_pos_r;
    push         = 1'b0;
    job          = '0;
    if (accept) begin
      unique case (in_ch.operation)
        OP_START: begin
          push = 1'b1;
          if (refuse) begin
            job.kind = JOB_REFUSED;
          end else if (in_ch.byte_count == '0) begin
            job.kind = JOB_SEL_DESEL;
          end else begin
            job.kind     = JOB_SEL_PAGE;
            job.addr     = in_ch.start_address;
            cur_addr_nxt = in_ch.start_address;
            end_addr_nxt = in_ch.start_address + in_ch.byte_count[ADDR_W-1:0];
            bip_nxt      = '0;
            buf_pos_nxt  = '0;
            phase_nxt    = PH_WAIT;
          end
        end
        OP_STATUS: begin
          if (in_ch.ready_req) begin
            if (phase_r == PH_WAIT) begin
              phase_nxt = PH_DATA;
              bip_nxt   = '0;
            end else if (phase_r == PH_RESET) begin
              push      = 1'b1;
              job.kind  = JOB_DESEL;
              phase_nxt = PH_IDLE;
            end
          end
        end
        OP_DATA: begin
          if (phase_r == PH_DATA) begin
            push          = 1'b1;
            job.data_byte = in_ch.flash_byte;
            job.offset    = buf_pos_r;
            job.kind      = JOB_DATA;
            buf_pos_nxt   = buf_pos_r + {{(ADDR_W-1){1'b0}}, 1'b1};
            cur_addr_nxt  = cur_inc;
            bip_nxt       = bip_r + {{(PAGE_W-1){1'b0}}, 1'b1};
            // The last byte of a page either ends the read or starts the next page.
            if (bip_r == '1) begin
              if (cur_inc == end_addr_r) begin
                job.kind  = JOB_DATA_DESEL;
                phase_nxt = PH_IDLE;
              end else begin
                job.kind  = JOB_DATA_PAGE;
                job.addr  = cur_inc;
                phase_nxt = PH_WAIT;
              end
            end
          end
        end
        OP_RESET: begin
          push      = 1'b1;
          job.kind  = JOB_RESET;
          phase_nxt = PH_RESET;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      cur_addr_r <= '0;
      end_addr_r <= '0;
      bip_r      <= '0;
      buf_pos_r  <= '0;
    end else begin
      phase_r    <= phase_nxt;
      cur_addr_r <= cur_addr_nxt;
      end_addr_r <= end_addr_nxt;
      bip_r      <= bip_nxt;
      buf_pos_r  <= buf_pos_nxt;
    end
  end

  `NLPRS_ASSERT_NEXT(a_refuse_hold, refused_start, $stable(phase_r), "refused start moved phase")
  `NLPRS_ASSERT_NEXT(a_reset_wait, reset_taken, phase_r == PH_RESET, "reset not entered")
  `NLPRS_ASSERT_SAME(a_push_needs_room, push, !q_full, "job produced while queue full")

endmodule

// File: rtl/nlprs_fifo.sv
// Small job queue between the front end and the back end.
// Depends on nlprs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nlprs_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  nlprs_pkg::job_t  push_job,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output nlprs_pkg::job_t  head
);
  import nlprs_pkg::*;

  job_t               q_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0] cnt_r;

  assign full  = (cnt_r == FIFO_CW'(FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = q_r[rd_ptr_r];

  // Storage, written only at the write pointer.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + {{(FIFO_AW-1){1'b0}}, 1'b1};
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + {{(FIFO_AW-1){1'b0}}, 1'b1};
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + {{(FIFO_CW-1){1'b0}}, 1'b1};
      end else if (pop && !push) begin
        cnt_r <= cnt_r - {{(FIFO_CW-1){1'b0}}, 1'b1};
      end
    end
  end

  `NLPRS_ASSERT_SAME(a_no_overflow, push, !full, "push into full queue")
  `NLPRS_ASSERT_SAME(a_no_underflow, pop, !empty, "pop from empty queue")

endmodule

// File: rtl/nlprs_back.sv
// Back end: expands each queued job into its result items through an output register.
// Depends on nlprs_pkg, nlprs_out_if and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nlprs_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             empty,
  input  nlprs_pkg::job_t  head,
  output logic             pop,
  nlprs_out_if.source      out_ch
);
  import nlprs_pkg::*;

  logic [STEP_W-1:0] step_r;
  logic              out_valid_r;
  logic [ACT_W-1:0]  action_r;
  logic [BYTE_W-1:0] bus_byte_r;
  logic [ADDR_W-1:0] offset_r;
  logic              last_r;

  logic              load;
  logic [STEP_W-1:0] last_step;
  logic [ACT_W-1:0]  res_action;
  logic [BYTE_W-1:0] res_byte;
  logic [ADDR_W-1:0] res_offset;
  logic              res_last;
  logic [ACT_W-1:0]  pg_action;
  logic [BYTE_W-1:0] pg_byte;

  assign load = !empty && (!out_valid_r || out_ch.ready);
  assign res_last = (step_r == last_step);
  assign pop = load && res_last;

  // Index of the final item for each job kind.
  always_comb begin
    unique case (head.kind) inside
      JOB_SEL_PAGE, JOB_DATA_PAGE:               last_step = STEP_W'(7);
      JOB_SEL_DESEL, JOB_DATA_DESEL, JOB_RESET:  last_step = STEP_W'(1);
      default:                                   last_step = '0;
    endcase
  end

  // Page read command: read command, two column bytes, three row bytes, confirm.
  always_comb begin
    pg_action = ACT_ADDR;
    pg_byte   = '0;
    unique case (step_r)
      3'd1: begin
        pg_action = ACT_CMD;
        pg_byte   = CMD_READ0;
      end
      3'd2: pg_byte = head.addr[7:0];
      3'd3: pg_byte = {5'b0, head.addr[PAGE_W-1:8]};
      3'd4: pg_byte = head.addr[PAGE_W+7:PAGE_W];
      3'd5: pg_byte = head.addr[PAGE_W+15:PAGE_W+8];
      3'd6: pg_byte = {6'b0, head.addr[ADDR_W-1:PAGE_W+16]};
      3'd7: begin
        pg_action = ACT_CMD;
        pg_byte   = CMD_READ1;
      end
      default: begin
        pg_action = ACT_ADDR;
        pg_byte   = '0;
      end
    endcase
  end

  // Result item for the current step of the head job.
  always_comb begin
    res_action = ACT_DESELECT;
    res_byte   = '0;
    res_offset = '0;
    if (step_r == '0) begin
      unique case (head.kind) inside
        JOB_REFUSED: res_action = ACT_REFUSED;
        JOB_SEL_DESEL, JOB_SEL_PAGE, JOB_RESET: res_action = ACT_SELECT;
        JOB_DATA, JOB_DATA_DESEL, JOB_DATA_PAGE: begin
          res_action = ACT_DATA;
          res_byte   = head.data_byte;
          res_offset = head.offset;
        end
        default: res_action = ACT_DESELECT;
      endcase
    end else begin
      unique case (head.kind) inside
        JOB_SEL_PAGE, JOB_DATA_PAGE: begin
          res_action = pg_action;
          res_byte   = pg_byte;
        end
        JOB_RESET: begin
          res_action = ACT_CMD;
          res_byte   = CMD_RESET;
        end
        default: res_action = ACT_DESELECT;
      endcase
    end
  end

  // Step counter and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        step_r      <= res_last ? '0 : step_r + {{(STEP_W-1){1'b0}}, 1'b1};
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      action_r   <= res_action;
      bus_byte_r <= res_byte;
      offset_r   <= res_offset;
      last_r     <= res_last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.action        = action_r;
  assign out_ch.bus_byte      = bus_byte_r;
  assign out_ch.buffer_offset = offset_r;
  assign out_ch.last          = last_r;

  `NLPRS_ASSERT_SAME(a_step_needs_job, step_r != '0, !empty, "mid-job step with empty queue")
  `NLPRS_ASSERT_NEXT(a_pop_gives_last, pop, out_valid_r && last_r, "job retired without last")

endmodule

// File: verif/tb_nand_large_page_read_sequencer.sv
`timescale 1ns / 1ps
// Self-checking testbench for the NAND large-page read sequencer.
// It drives directed and random items into in_ch and checks every item on out_ch.
// Depends on nlprs_pkg, the nlprs_if interfaces and nand_large_page_read_sequencer.

module tb_nand_large_page_read_sequencer;
  import nlprs_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int LIMIT_NS     = 100_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MIX_ITEMS    = 110;
  localparam int READ_RUNS    = 4;
  localparam int READ_BUDGET  = 6;
  localparam int TOP_BUDGET   = 12;

  localparam logic [ADDR_W-1:0]  TOP_PAGE   = 29'h1FFF_F800;
  localparam logic [COUNT_W-1:0] ONE_PAGE   = 30'h0000_0800;
  localparam logic [COUNT_W-1:0] FULL_SPACE = 30'h2000_0000;

  // Where the sequence stands between input items.
  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_WAIT,
    SEQ_DATA,
    SEQ_RESET
  } seq_phase_t;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [ADDR_W-1:0]  start_address;
    logic [COUNT_W-1:0] byte_count;
    logic               ready_req;
    logic [BYTE_W-1:0]  flash_byte;
  } seq_item_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [BYTE_W-1:0] bus_byte;
    logic [ADDR_W-1:0] buffer_offset;
    logic              last;
  } bus_action_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  nlprs_in_if  in_ch ();
  nlprs_out_if out_ch ();

  nand_large_page_read_sequencer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #HALF_PERIOD clk = ~clk;

  // Sequencer state as the testbench sees it.
  seq_phase_t        seq_phase;
  logic [ADDR_W-1:0]  flash_addr;
  logic [COUNT_W-1:0] stop_addr;
  logic [PAGE_W-1:0]  page_byte;
  logic [ADDR_W-1:0]  buf_pos;

  // Bus actions still owed by the block, oldest first.
  bus_action_t pending_actions[$];
  int          actions_this_item;

  int fail_count   = 0;
  int items_sent   = 0;
  int actions_seen = 0;
  bit idle_en      = 1'b0;
  bit stall_en     = 1'b0;
  int stall_left   = 0;

  // Length of an idle stretch: mostly short, now and then long.
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 93) return $urandom_range(3, 6);
    return $urandom_range(8, 24);
  endfunction

  function automatic seq_item_t mk_item(input logic [OP_W-1:0] op,
                                        input logic [ADDR_W-1:0] start,
                                        input logic [COUNT_W-1:0] count,
                                        input logic rdy,
                                        input logic [BYTE_W-1:0] fbyte);
    seq_item_t it;
    it.operation     = op;
    it.start_address = start;
    it.byte_count    = count;
    it.ready_req     = rdy;
    it.flash_byte    = fbyte;
    return it;
  endfunction

  // An item of the given operation with every other field random.
  function automatic seq_item_t rand_item(input logic [OP_W-1:0] op);
    return mk_item(op, ADDR_W'($urandom), COUNT_W'($urandom), 1'($urandom),
                   BYTE_W'($urandom));
  endfunction

  task automatic owe_action(input logic [ACT_W-1:0] act, input logic [BYTE_W-1:0] b,
                            input logic [ADDR_W-1:0] off);
    pending_actions.push_back('{action: act, bus_byte: b, buffer_offset: off, last: 1'b0});
    actions_this_item++;
  endtask

  // Command, five address bytes and confirm command for one page read.
  task automatic owe_page_cmds(input logic [ADDR_W-1:0] addr);
    logic [PAGE_W-1:0]        col;
    logic [ADDR_W-PAGE_W-1:0] page;
    col  = addr[PAGE_W-1:0];
    page = addr[ADDR_W-1:PAGE_W];
    owe_action(ACT_CMD, CMD_READ0, '0);
    owe_action(ACT_ADDR, col[7:0], '0);
    owe_action(ACT_ADDR, {5'b0, col[10:8]}, '0);
    owe_action(ACT_ADDR, page[7:0], '0);
    owe_action(ACT_ADDR, page[15:8], '0);
    owe_action(ACT_ADDR, {6'b0, page[17:16]}, '0);
    owe_action(ACT_CMD, CMD_READ1, '0);
  endtask

  // Advance the sequence by one accepted item and queue the bus actions it causes.
  task automatic predict_actions(input seq_item_t it);
    actions_this_item = 0;
    case (it.operation)
      OP_START: begin
        if (seq_phase != SEQ_IDLE || it.start_address[PAGE_W-1:0] != '0 ||
            it.byte_count[PAGE_W-1:0] != '0 || it.byte_count > FULL_SPACE) begin
          owe_action(ACT_REFUSED, 8'h00, '0);
        end else begin
          owe_action(ACT_SELECT, 8'h00, '0);
          if (it.byte_count == '0) begin
            owe_action(ACT_DESELECT, 8'h00, '0);
          end else begin
            flash_addr = it.start_address;
            stop_addr  = {1'b0, it.start_address} + it.byte_count;
            page_byte  = '0;
            buf_pos    = '0;
            owe_page_cmds(it.start_address);
            seq_phase  = SEQ_WAIT;
          end
        end
      end
      OP_STATUS: begin
        if (it.ready_req) begin
          if (seq_phase == SEQ_WAIT) begin
            seq_phase = SEQ_DATA;
            page_byte = '0;
          end else if (seq_phase == SEQ_RESET) begin
            owe_action(ACT_DESELECT, 8'h00, '0);
            seq_phase = SEQ_IDLE;
          end
        end
      end
      OP_DATA: begin
        if (seq_phase == SEQ_DATA) begin
          owe_action(ACT_DATA, it.flash_byte, buf_pos);
          buf_pos    = buf_pos + ADDR_W'(1);
          flash_addr = flash_addr + ADDR_W'(1);
          page_byte  = page_byte + PAGE_W'(1);
          // A whole page is in: either the read is over or the next page starts.
          if (page_byte == '0) begin
            if (flash_addr == stop_addr[ADDR_W-1:0]) begin
              owe_action(ACT_DESELECT, 8'h00, '0);
              seq_phase = SEQ_IDLE;
            end else begin
              owe_page_cmds(flash_addr);
              seq_phase = SEQ_WAIT;
            end
          end
        end
      end
      OP_RESET: begin
        owe_action(ACT_SELECT, 8'h00, '0);
        owe_action(ACT_CMD, CMD_RESET, '0);
        seq_phase = SEQ_RESET;
      end
    endcase
    if (actions_this_item > 0) pending_actions[pending_actions.size()-1].last = 1'b1;
  endtask

  // Present one item at a falling edge, hold it until accepted, then maybe idle.
  task automatic send_item(input seq_item_t it);
    int gap;
    @(negedge clk);
    in_ch.valid         <= 1'b1;
    in_ch.operation     <= it.operation;
    in_ch.start_address <= it.start_address;
    in_ch.byte_count    <= it.byte_count;
    in_ch.ready_req     <= it.ready_req;
    in_ch.flash_byte    <= it.flash_byte;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_actions(it);
    items_sent++;
    gap = (idle_en && $urandom_range(0, 99) < 35) ? pick_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // One read request followed by status samples and data bytes, at most budget
  // items before any reset; a read still running then is abandoned by a reset request.
  // With noise, stray and refused items are mixed into the sequence.
  task automatic run_read(input logic [ADDR_W-1:0] start, input logic [COUNT_W-1:0] count,
                          input bit noisy, input int budget);
    int r;
    int sent;
    sent = 1;
    send_item(mk_item(OP_START, start, count, 1'($urandom), BYTE_W'($urandom)));
    while ((seq_phase == SEQ_WAIT || seq_phase == SEQ_DATA) && sent < budget) begin
      r = $urandom_range(0, 499);
      if (seq_phase == SEQ_WAIT) begin
        if (noisy && r < 40)
          send_item(rand_item(OP_DATA));
        else
          send_item(mk_item(OP_STATUS, ADDR_W'($urandom), COUNT_W'($urandom),
                            (r % 3) != 0, BYTE_W'($urandom)));
      end else if (noisy && r < 2) begin
        send_item(rand_item(OP_START));
      end else if (noisy && r < 5) begin
        send_item(rand_item(OP_STATUS));
      end else begin
        send_item(rand_item(OP_DATA));
      end
      sent++;
    end
    if (seq_phase != SEQ_IDLE) begin
      send_item(rand_item(OP_RESET));
      send_item(mk_item(OP_STATUS, '0, '0, 1'b1, 8'h00));
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Refusals, zero count, reset handling and ignored items, a few items each.
  task automatic test_directed();
    idle_en  = 1'b1;
    stall_en = 1'b1;
    send_item(mk_item(OP_START, 29'h0000_0400, ONE_PAGE, 1'b0, 8'h00));
    send_item(mk_item(OP_START, '0, 30'h0000_0801, 1'b0, 8'h00));
    send_item(mk_item(OP_START, '0, FULL_SPACE + ONE_PAGE, 1'b0, 8'h00));
    send_item(mk_item(OP_START, TOP_PAGE, 30'h3FFF_F800, 1'b1, 8'hff));
    send_item(mk_item(OP_START, TOP_PAGE, '0, 1'b0, 8'h00));
    // Status and data in idle are ignored.
    send_item(mk_item(OP_STATUS, '0, '0, 1'b1, 8'h00));
    send_item(mk_item(OP_DATA, '0, '0, 1'b0, 8'hff));
    // Reset from idle, repeated while pending, then finished by a ready sample.
    send_item(mk_item(OP_RESET, '0, '0, 1'b0, 8'h00));
    send_item(mk_item(OP_STATUS, '0, '0, 1'b0, 8'h00));
    send_item(mk_item(OP_RESET, '0, '0, 1'b0, 8'h00));
    send_item(mk_item(OP_STATUS, '0, '0, 1'b1, 8'h00));
    // Largest legal count, then a start while busy and a stray byte.
    send_item(mk_item(OP_START, '0, FULL_SPACE, 1'b0, 8'h00));
    send_item(mk_item(OP_START, 29'h0000_0800, ONE_PAGE, 1'b0, 8'h00));
    send_item(mk_item(OP_DATA, '0, '0, 1'b0, 8'h5a));
    send_item(mk_item(OP_STATUS, '0, '0, 1'b0, 8'h00));
    send_item(mk_item(OP_STATUS, '0, '0, 1'b1, 8'h00));
    send_item(mk_item(OP_DATA, '0, '0, 1'b0, 8'h00));
    send_item(mk_item(OP_DATA, '0, '0, 1'b0, 8'hff));
    send_item(mk_item(OP_DATA, '0, '0, 1'b0, 8'ha5));
    send_item(mk_item(OP_STATUS, '0, '0, 1'b1, 8'h00));
    send_item(mk_item(OP_START, '0, ONE_PAGE, 1'b0, 8'h00));
    // Reset abandons the read in the middle of the data.
    send_item(mk_item(OP_RESET, '0, '0, 1'b0, 8'h00));
    send_item(mk_item(OP_STATUS, '0, '0, 1'b1, 8'h00));
  endtask

  // A two-page read from the top page, so the row bytes carry the highest page.
  task automatic test_top_page();
    run_read(TOP_PAGE, COUNT_W'(2) * ONE_PAGE, 1'b0, TOP_BUDGET);
  endtask

  // Random operations with random fields, biased toward aligned starts.
  task automatic test_random_mix();
    int r;
    for (int i = 0; i < MIX_ITEMS; i++) begin
      idle_en  = ((i / 45) % 4) != 3;
      stall_en = ((i / 45) % 4) != 2;
      r = $urandom_range(0, 99);
      if (r < 20)
        send_item(mk_item(OP_START, {18'($urandom_range(0, 18'h3ffff)), 11'b0},
                          COUNT_W'($urandom_range(0, 3)) * ONE_PAGE, 1'($urandom),
                          BYTE_W'($urandom)));
      else if (r < 30)
        send_item(rand_item(OP_START));
      else if (r < 55)
        send_item(rand_item(OP_STATUS));
      else if (r < 85)
        send_item(rand_item(OP_DATA));
      else
        send_item(rand_item(OP_RESET));
    end
  endtask

  // Short reads at random aligned addresses with noise mixed in.
  task automatic test_random_reads();
    logic [ADDR_W-1:0] start;
    int                pages;
    // Bring the sequence back to idle after the random mix.
    if (seq_phase != SEQ_IDLE) begin
      send_item(rand_item(OP_RESET));
      send_item(mk_item(OP_STATUS, ADDR_W'($urandom), COUNT_W'($urandom), 1'b1,
                        BYTE_W'($urandom)));
    end
    for (int k = 0; k < READ_RUNS; k++) begin
      idle_en  = (k != 1);
      stall_en = (k != 2);
      pages    = ($urandom_range(0, 3) == 0) ? 2 : 1;
      start    = ($urandom_range(0, 3) == 0) ? TOP_PAGE
                                             : {18'($urandom_range(0, 18'h3ffff)), 11'b0};
      run_read(start, COUNT_W'(pages) * ONE_PAGE, 1'b1, READ_BUDGET);
    end
  endtask

  // Result side: random back-pressure, changed at the falling edge.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (stall_en && $urandom_range(0, 99) < 25) begin
      out_ch.ready <= 1'b0;
      stall_left = pick_len() - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Compare each accepted result item with the oldest owed action.
  always @(posedge clk) begin : check_actions
    bus_action_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      actions_seen++;
      if (pending_actions.size() == 0) begin
        fail_count++;
        $display("%0t ns: unexpected result: action %0d byte %02h offset %0h last %0b",
                 $time, out_ch.action, out_ch.bus_byte, out_ch.buffer_offset, out_ch.last);
      end else begin
        want = pending_actions.pop_front();
        check_field("action", 32'(want.action), 32'(out_ch.action));
        check_field("bus_byte", 32'(want.bus_byte), 32'(out_ch.bus_byte));
        check_field("buffer_offset", 32'(want.buffer_offset), 32'(out_ch.buffer_offset));
        check_field("last", 32'(want.last), 32'(out_ch.last));
      end
    end
  end

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.operation     = OP_STATUS;
    in_ch.start_address = '0;
    in_ch.byte_count    = '0;
    in_ch.ready_req     = 1'b0;
    in_ch.flash_byte    = '0;
    out_ch.ready        = 1'b0;
    seq_phase  = SEQ_IDLE;
    flash_addr = '0;
    stop_addr  = '0;
    page_byte  = '0;
    buf_pos    = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_top_page();
    test_random_mix();
    test_random_reads();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    stall_en = 1'b0;
    while (pending_actions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d input items and checked %0d result items.", items_sent, actions_seen);
    $display("Covered refusals, zero count, resets, top-page addressing and random reads.");
    if (fail_count == 0) begin
      $display("** nand_large_page_read_sequencer: PASSED **");
    end else begin
      $display("** nand_large_page_read_sequencer: FAILED **");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #LIMIT_NS;
    $display("** nand_large_page_read_sequencer: FAILED **");
    $finish;
  end

endmodule
